@@ sv/rectangle_zone_hit_table_assert.svh @@
// Assertion macros shared by the checker of the rectangle zone hit table.
// No dependencies.
`ifndef RECTANGLE_ZONE_HIT_TABLE_ASSERT_SVH
`define RECTANGLE_ZONE_HIT_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RZHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rectangle zone hit table check failed");

// The consequent must hold in the cycle after the antecedent.
`define RZHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rectangle zone hit table check failed");

// Like the one above, but also checked while reset is applied.
`define RZHT_ASSERT_NEXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rectangle zone hit table check failed");

`endif

@@ sv/rzht_pkg.sv @@
// Types and codes of the rectangle zone hit table.
// No dependencies; used by the cell and the top level.
package rzht_pkg;

    typedef enum logic [1:0] {
        KIND_CREATE  = 2'd0,
        KIND_DELETE  = 2'd1,
        KIND_POINTER = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] x_pos;
        logic [11:0] y_pos;
        logic [12:0] right_excl;
        logic [12:0] bottom_excl;
        logic [15:0] tag;
        logic        left_en;
        logic        right_en;
        logic [5:0]  slot;
        logic        left_button;
        logic        right_button;
        logic        done;
        logic [5:0]  res_slot;
        logic        left_fire;
        logic        right_fire;
    } t_token;

endpackage

@@ sv/rzht_if.sv @@
// Valid/ready channel interfaces of the rectangle zone hit table.
// Depends on nothing but the field widths of the block.
interface rzht_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic [12:0] width;
    logic [12:0] height;
    logic [15:0] tag;
    logic        has_left_handler;
    logic        has_right_handler;
    logic [5:0]  slot;
    logic        left_button;
    logic        right_button;

    modport source (
        output valid, kind, x_pos, y_pos, width, height, tag,
               has_left_handler, has_right_handler, slot, left_button, right_button,
        input  ready
    );
    modport sink (
        input  valid, kind, x_pos, y_pos, width, height, tag,
               has_left_handler, has_right_handler, slot, left_button, right_button,
        output ready
    );
endinterface

interface rzht_out_if;
    logic        valid;
    logic        ready;
    logic        created;
    logic [5:0]  slot_out;
    logic        hit;
    logic        left_fire;
    logic        right_fire;
    logic [15:0] tag_out;

    modport source (
        output valid, created, slot_out, hit, left_fire, right_fire, tag_out,
        input  ready
    );
    modport sink (
        input  valid, created, slot_out, hit, left_fire, right_fire, tag_out,
        output ready
    );
endinterface

@@ sv/rzht_cell.sv @@
// One zone slot of the table and the pipeline stage that follows it.
// Depends on rzht_pkg for the token type and the item kinds.
module rzht_cell
    import rzht_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_vld,
    input  t_token i_tok,
    output logic   o_vld,
    output t_token o_tok
);

    logic        r_valid, n_valid;
    logic        r_latched, n_latched;
    logic        n_write;
    logic [11:0] r_left;
    logic [11:0] r_top;
    logic [12:0] r_right;
    logic [12:0] r_bottom;
    logic [15:0] r_tag;
    logic        r_left_en;
    logic        r_right_en;
    logic        r_vld;
    t_token      r_tok, n_tok;
    logic        w_inside;
    logic        w_latch_seen;

    assign w_inside = r_valid
        && (i_tok.x_pos >= r_left) && ({1'b0, i_tok.x_pos} < r_right)
        && (i_tok.y_pos >= r_top) && ({1'b0, i_tok.y_pos} < r_bottom);
    assign w_latch_seen = i_tok.left_button && r_latched;

    always_comb begin
        n_tok     = i_tok;
        n_valid   = r_valid;
        n_latched = r_latched;
        n_write   = 1'b0;
        case (i_tok.kind)
            KIND_CREATE: begin
                if (!i_tok.done && !r_valid) begin
                    n_valid        = 1'b1;
                    n_latched      = 1'b0;
                    n_write        = 1'b1;
                    n_tok.done     = 1'b1;
                    n_tok.res_slot = 6'(INDEX);
                end
            end
            KIND_DELETE: begin
                if (32'(i_tok.slot) == 32'(INDEX)) begin
                    n_valid = 1'b0;
                end
            end
            KIND_POINTER: begin
                n_latched = w_latch_seen;
                if (!i_tok.done && w_inside) begin
                    n_tok.done     = 1'b1;
                    n_tok.res_slot = 6'(INDEX);
                    n_tok.tag      = r_tag;
                    if (!w_latch_seen) begin
                        n_latched        = i_tok.left_button;
                        n_tok.left_fire  = i_tok.left_button && r_left_en;
                        n_tok.right_fire = i_tok.right_button && r_right_en;
                    end
                end
            end
            default: begin
                n_tok = i_tok;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_latched <= 1'b0;
            r_vld     <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
            if (i_vld) begin
                r_valid   <= n_valid;
                r_latched <= n_latched;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok <= n_tok;
            if (i_vld && n_write) begin
                r_left     <= i_tok.x_pos;
                r_top      <= i_tok.y_pos;
                r_right    <= i_tok.right_excl;
                r_bottom   <= i_tok.bottom_excl;
                r_tag      <= i_tok.tag;
                r_left_en  <= i_tok.left_en;
                r_right_en <= i_tok.right_en;
            end
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

@@ sv/rectangle_zone_hit_table.sv @@
// Top level of the rectangle zone hit table: a chain of zone cells.
// Depends on rzht_pkg, the channel interfaces in rzht_if.sv and rzht_cell.
//
// Items arrive on i_in as valid/ready transfers: create a zone, delete a
// zone, or a pointer event. Every item gives exactly one result on o_out.
// Each item walks down a row of ZONE_COUNT cells, one cell per cycle while
// the chain is not stalled, and is registered in each cell's stage; each
// cell holds one zone slot and applies the item to it, and lower slots are
// met first, so the first free or first matching slot wins.
// Throughput: one item per cycle when not stalled, as items follow each other
// down the chain; the last cell's stage register is the output register.
// When the receiver stalls, the whole chain holds and i_in.ready drops;
// it rises again in the cycle the waiting result is taken.
// Reset clears every zone's valid and latch flag and empties the chain;
// there is no clearing pass.
module rectangle_zone_hit_table
    import rzht_pkg::*;
#(
    parameter int ZONE_COUNT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rzht_in_if.sink     i_in,
    rzht_out_if.source  o_out
);

    logic                  w_adv;
    logic   [ZONE_COUNT:0] w_vld;
    t_token                w_tok [ZONE_COUNT+1];
    t_token                w_last;

    assign w_adv      = !w_vld[ZONE_COUNT] || o_out.ready;
    assign i_in.ready = w_adv;

    assign w_vld[0]              = i_in.valid;
    assign w_tok[0].kind         = t_kind'(i_in.kind);
    assign w_tok[0].x_pos        = i_in.x_pos;
    assign w_tok[0].y_pos        = i_in.y_pos;
    assign w_tok[0].right_excl   = 13'({1'b0, i_in.x_pos} + i_in.width);
    assign w_tok[0].bottom_excl  = 13'({1'b0, i_in.y_pos} + i_in.height);
    assign w_tok[0].tag          = i_in.tag;
    assign w_tok[0].left_en      = i_in.has_left_handler;
    assign w_tok[0].right_en     = i_in.has_right_handler;
    assign w_tok[0].slot         = i_in.slot;
    assign w_tok[0].left_button  = i_in.left_button;
    assign w_tok[0].right_button = i_in.right_button;
    assign w_tok[0].done         = 1'b0;
    assign w_tok[0].res_slot     = '0;
    assign w_tok[0].left_fire    = 1'b0;
    assign w_tok[0].right_fire   = 1'b0;

    for (genvar g = 0; g < ZONE_COUNT; g++) begin : g_cell
        rzht_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_vld[g]),
            .i_tok   (w_tok[g]),
            .o_vld   (w_vld[g+1]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_last = w_tok[ZONE_COUNT];

    assign o_out.valid      = w_vld[ZONE_COUNT];
    assign o_out.created    = (w_last.kind == KIND_CREATE) && w_last.done;
    assign o_out.hit        = (w_last.kind == KIND_POINTER) && w_last.done;
    assign o_out.slot_out   = w_last.done ? w_last.res_slot : '0;
    assign o_out.left_fire  = w_last.left_fire;
    assign o_out.right_fire = w_last.right_fire;
    assign o_out.tag_out    = ((w_last.kind == KIND_POINTER) && w_last.done) ?
                              w_last.tag : '0;

endmodule

@@ sv/rzht_check.sv @@
// Port-level checker of the rectangle zone hit table and its bind.
// Depends on rectangle_zone_hit_table_assert.svh and the top level's ports.
`include "rectangle_zone_hit_table_assert.svh"

module rzht_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_created,
    input logic [5:0]  i_slot_out,
    input logic        i_hit,
    input logic        i_left_fire,
    input logic        i_right_fire,
    input logic [15:0] i_tag_out
);

    logic        w_stall;
    logic        w_fire;
    logic        w_miss;
    logic [25:0] w_fields;

    assign w_stall  = i_out_valid && !i_out_ready;
    assign w_fire   = i_out_valid && (i_left_fire || i_right_fire);
    assign w_miss   = i_out_valid && !i_hit && !i_created;
    assign w_fields = {i_created, i_slot_out, i_hit, i_left_fire, i_right_fire, i_tag_out};

    `RZHT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid && $stable(w_fields))
    `RZHT_ASSERT_NOW(a_ready_follows_out, i_clk, i_rst_n, 1'b1, i_in_ready == !w_stall)
    `RZHT_ASSERT_NOW(a_fire_needs_hit, i_clk, i_rst_n, w_fire, i_hit && !i_created)
    `RZHT_ASSERT_NOW(a_miss_is_quiet, i_clk, i_rst_n, w_miss, {i_slot_out, i_tag_out} == 22'd0)
    `RZHT_ASSERT_NEXT_ANY(a_reset_empties, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind rectangle_zone_hit_table rzht_check u_rzht_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_created    (o_out.created),
    .i_slot_out   (o_out.slot_out),
    .i_hit        (o_out.hit),
    .i_left_fire  (o_out.left_fire),
    .i_right_fire (o_out.right_fire),
    .i_tag_out    (o_out.tag_out)
);
